/* hw/rtl/plbm_pkg.sv */
// shared types and constants for the piecewise linear breakpoint map
// used by plbm_div and piecewise_linear_breakpoint_map_unit
package plbm_pkg;

  localparam int BP_W      = 49;
  localparam int IDX_W     = 3;
  localparam int CNT_W     = 3;
  localparam int VAL_W     = 32;
  localparam int NORM_W    = 17;
  localparam int DIFF_W    = 33;
  localparam int MB_W      = 18;
  localparam int PROD_W    = 51;
  localparam int NUM_W     = 50;
  localparam int DEN_W     = 33;

  localparam logic [IDX_W-1:0]  REG_POINT_COUNT = 3'd6;
  localparam logic [CNT_W-1:0]  POINT_COUNT_RST = 3'd2;
  localparam logic signed [VAL_W-1:0] NORM_ONE  = 32'sd65536;

  typedef enum logic {
    KIND_TO_RANGE = 1'b0,
    KIND_TO_NORM  = 1'b1
  } kind_t;

  // result fields that ride alongside the division
  typedef struct packed {
    logic                    fixed_en;
    logic signed [VAL_W-1:0] fixed_val;
    logic                    empty;
    logic                    zden;
    logic signed [VAL_W-1:0] y0;
  } side_t;

endpackage

/* hw/rtl/plbm_div.sv */
// pipelined restoring divider on magnitudes, two quotient bits per stage
// depends on plbm_pkg for widths and the side-band struct
module plbm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [plbm_pkg::NUM_W-1:0]    num,
  input  logic [plbm_pkg::DEN_W-1:0]    den,
  input  logic                          neg,
  input  plbm_pkg::side_t               side,
  output logic                          out_valid,
  output logic [plbm_pkg::NUM_W-1:0]    quo,
  output logic                          out_neg,
  output plbm_pkg::side_t               out_side
);

  localparam int NW     = plbm_pkg::NUM_W;
  localparam int DW     = plbm_pkg::DEN_W;
  localparam int RW     = DW + 1;
  localparam int STEPS  = 2;
  localparam int STAGES = (NW + STEPS - 1) / STEPS;

  logic                  vld  [STAGES];
  logic [RW-1:0]         rem  [STAGES];
  logic [NW-1:0]         nsh  [STAGES];
  logic [NW-1:0]         qa   [STAGES];
  logic [DW-1:0]         dreg [STAGES];
  logic                  ngr  [STAGES];
  plbm_pkg::side_t       sreg [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic            v_in;
    logic [RW-1:0]   r_in;
    logic [NW-1:0]   n_in;
    logic [NW-1:0]   q_in;
    logic [DW-1:0]   d_in;
    logic            ng_in;
    plbm_pkg::side_t s_in;
    logic [RW-1:0]   r_next;
    logic [NW-1:0]   n_next;
    logic [NW-1:0]   q_next;

    if (g == 0) begin : g_first
      assign v_in  = in_valid;
      assign r_in  = '0;
      assign n_in  = num;
      assign q_in  = '0;
      assign d_in  = den;
      assign ng_in = neg;
      assign s_in  = side;
    end else begin : g_rest
      assign v_in  = vld[g-1];
      assign r_in  = rem[g-1];
      assign n_in  = nsh[g-1];
      assign q_in  = qa[g-1];
      assign d_in  = dreg[g-1];
      assign ng_in = ngr[g-1];
      assign s_in  = sreg[g-1];
    end

    always_comb begin
      r_next = r_in;
      n_next = n_in;
      q_next = q_in;
      for (int j = 0; j < STEPS; j++) begin
        if (g * STEPS + j < NW) begin
          r_next = {r_next[RW-2:0], n_next[NW-1]};
          n_next = {n_next[NW-2:0], 1'b0};
          q_next = {q_next[NW-2:0], 1'b0};
          if (r_next >= {1'b0, d_in}) begin
            r_next    = r_next - {1'b0, d_in};
            q_next[0] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g]  <= r_next;
        nsh[g]  <= n_next;
        qa[g]   <= q_next;
        dreg[g] <= d_in;
        ngr[g]  <= ng_in;
        sreg[g] <= s_in;
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign quo       = qa[STAGES-1];
  assign out_neg   = ngr[STAGES-1];
  assign out_side  = sreg[STAGES-1];

endmodule

/* hw/rtl/piecewise_linear_breakpoint_map_unit.sv */
// top level of the piecewise linear breakpoint map
// depends on plbm_pkg and plbm_div
//
// Each beat maps one value through the breakpoint table, normalized to range
// (kind 0) or range to normalized (kind 1). The pipeline takes one beat per
// cycle, and any stall on the output holds the whole pipeline. Its stages:
// segment search, differences, multiply, sign split, 25 divider stages
// producing two quotient bits each, and the final add with saturation.
// Configuration registers are written through cfg_we / cfg_index / cfg_data
// and must only change while no beat is in flight.
module piecewise_linear_breakpoint_map_unit #(
  parameter int MAX_POINTS = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [plbm_pkg::IDX_W-1:0] cfg_index,
  input  logic [plbm_pkg::BP_W-1:0]  cfg_data,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [31:0]                s_tdata,   // operand_value
  input  logic                       s_tuser,   // kind
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [31:0]                m_tdata,   // mapped_value
  output logic                       m_tuser    // empty_range
);

  localparam int VW = plbm_pkg::VAL_W;
  localparam int DF = plbm_pkg::DIFF_W;

  logic [plbm_pkg::BP_W-1:0]  breakpoint [MAX_POINTS];
  logic [plbm_pkg::CNT_W-1:0] point_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_POINTS; i++) breakpoint[i] <= '0;
      point_count <= plbm_pkg::POINT_COUNT_RST;
    end else if (cfg_we) begin
      if (cfg_index == plbm_pkg::REG_POINT_COUNT) begin
        point_count <= cfg_data[plbm_pkg::CNT_W-1:0];
      end else if (32'(cfg_index) < MAX_POINTS) begin
        breakpoint[cfg_index[$clog2(MAX_POINTS)-1:0]] <= cfg_data;
      end
    end
  end

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // breakpoint fields
  logic signed [VW-1:0] bp_rng [MAX_POINTS];
  logic signed [VW-1:0] bp_nrm [MAX_POINTS];
  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      bp_rng[i] = breakpoint[i][VW-1:0];
      bp_nrm[i] = VW'(breakpoint[i][plbm_pkg::BP_W-1:VW]);
    end
  end

  // stage 1: clamp and segment search
  logic [plbm_pkg::CNT_W-1:0] last;
  logic signed [VW-1:0] lo, hi, xin, xc;
  logic signed [VW-1:0] in0_c, in1_c, out0_c, out1_c;
  logic found, is_norm, empty_c;

  always_comb begin
    if (point_count < 3'd2) last = 3'd1;
    else if (32'(point_count) > MAX_POINTS) last = plbm_pkg::CNT_W'(MAX_POINTS - 1);
    else last = point_count - 3'd1;
    lo = bp_rng[0];
    hi = bp_rng[0];
    for (int i = 1; i < MAX_POINTS; i++) begin
      if (last == plbm_pkg::CNT_W'(i)) hi = bp_rng[i];
    end
    empty_c = (hi <= lo);
    is_norm = (plbm_pkg::kind_t'(s_tuser) == plbm_pkg::KIND_TO_NORM);
    xin = s_tdata;
    if (!is_norm) begin
      if (xin < 0) xc = '0;
      else if (xin > plbm_pkg::NORM_ONE) xc = plbm_pkg::NORM_ONE;
      else xc = xin;
    end else begin
      if (xin < lo) xc = lo;
      else if (xin > hi) xc = hi;
      else xc = xin;
    end
    found  = 1'b0;
    in0_c  = '0;
    in1_c  = '0;
    out0_c = '0;
    out1_c = '0;
    for (int i = 1; i < MAX_POINTS; i++) begin
      if (!found && plbm_pkg::CNT_W'(i) <= last &&
          xc <= (is_norm ? bp_rng[i] : bp_nrm[i])) begin
        found  = 1'b1;
        in0_c  = is_norm ? bp_rng[i-1] : bp_nrm[i-1];
        in1_c  = is_norm ? bp_rng[i]   : bp_nrm[i];
        out0_c = is_norm ? bp_nrm[i-1] : bp_rng[i-1];
        out1_c = is_norm ? bp_nrm[i]   : bp_rng[i];
      end
    end
  end

  logic s1_valid, s1_kind, s1_empty, s1_found;
  logic signed [VW-1:0] s1_x, s1_in0, s1_in1, s1_out0, s1_out1, s1_hi;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind  <= is_norm;
      s1_empty <= empty_c;
      s1_found <= found;
      s1_x     <= xc;
      s1_in0   <= in0_c;
      s1_in1   <= in1_c;
      s1_out0  <= out0_c;
      s1_out1  <= out1_c;
      s1_hi    <= hi;
    end
  end

  // stage 2: differences
  logic signed [DF-1:0] off_c, den_c, span_c;
  plbm_pkg::side_t side2_c;
  always_comb begin
    off_c  = DF'(s1_x) - DF'(s1_in0);
    den_c  = DF'(s1_in1) - DF'(s1_in0);
    span_c = DF'(s1_out1) - DF'(s1_out0);
    side2_c.fixed_en  = s1_empty || !s1_found;
    side2_c.fixed_val = s1_empty ? '0 : (s1_kind ? plbm_pkg::NORM_ONE : s1_hi);
    side2_c.empty     = s1_empty;
    side2_c.zden      = (den_c == '0);
    side2_c.y0        = s1_out0;
  end

  logic s2_valid;
  logic signed [DF-1:0] s2_ma, s2_den;
  logic signed [plbm_pkg::MB_W-1:0] s2_mb;
  plbm_pkg::side_t s2_side;
  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en) s2_valid <= s1_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      // the normalized difference always fits in 18 bits
      s2_ma   <= s1_kind ? off_c : span_c;
      s2_mb   <= s1_kind ? span_c[plbm_pkg::MB_W-1:0] : off_c[plbm_pkg::MB_W-1:0];
      s2_den  <= den_c;
      s2_side <= side2_c;
    end
  end

  // stage 3: multiply
  logic s3_valid;
  logic signed [plbm_pkg::PROD_W-1:0] s3_prod;
  logic signed [DF-1:0] s3_den;
  plbm_pkg::side_t s3_side;
  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (en) s3_valid <= s2_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_prod <= plbm_pkg::PROD_W'(s2_ma) * plbm_pkg::PROD_W'(s2_mb);
      s3_den  <= s2_den;
      s3_side <= s2_side;
    end
  end

  // stage 4: magnitudes and quotient sign
  logic [plbm_pkg::PROD_W-1:0] pmag;
  logic [DF-1:0] dmag;
  assign pmag = s3_prod[plbm_pkg::PROD_W-1] ? -s3_prod : s3_prod;
  assign dmag = s3_den[DF-1] ? -s3_den : s3_den;

  logic s4_valid, s4_neg;
  logic [plbm_pkg::NUM_W-1:0] s4_num;
  logic [plbm_pkg::DEN_W-1:0] s4_den;
  plbm_pkg::side_t s4_side;
  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else if (en) s4_valid <= s3_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_num  <= pmag[plbm_pkg::NUM_W-1:0];
      s4_den  <= dmag;
      s4_neg  <= s3_prod[plbm_pkg::PROD_W-1] ^ s3_den[DF-1];
      s4_side <= s3_side;
    end
  end

  logic dv_valid, dv_neg;
  logic [plbm_pkg::NUM_W-1:0] dv_quo;
  plbm_pkg::side_t dv_side;

  plbm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s4_valid),
    .num       (s4_num),
    .den       (s4_den),
    .neg       (s4_neg),
    .side      (s4_side),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .out_neg   (dv_neg),
    .out_side  (dv_side)
  );

  // final add and saturation
  localparam int SW = plbm_pkg::NUM_W + 2;
  logic signed [SW-1:0] q_s, sum;
  logic signed [VW-1:0] res;
  always_comb begin
    q_s = dv_neg ? -SW'({1'b0, dv_quo}) : SW'({1'b0, dv_quo});
    sum = SW'(dv_side.y0) + q_s;
    if (dv_side.fixed_en) res = dv_side.fixed_val;
    else if (dv_side.zden) res = dv_side.y0;
    else if (sum > SW'(32'sh7fffffff)) res = 32'sh7fffffff;
    else if (sum < -SW'(64'sh80000000)) res = 32'sh80000000;
    else res = sum[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= dv_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= res;
      m_tuser <= dv_side.empty;
    end
  end

endmodule

/* dv/tb_top.sv */
// self-checking testbench for piecewise_linear_breakpoint_map_unit
// depends on plbm_pkg and the unit rtl; predicts each beat and compares in order
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = 6;
  localparam int LATENCY = 30;

  typedef struct {
    logic signed [31:0] value;
    logic               empty;
  } map_result_t;

  typedef struct {
    plbm_pkg::kind_t    kind;
    logic signed [31:0] operand;
    logic               known;     // expected value typed in
    logic signed [31:0] value;
    logic               empty;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [plbm_pkg::IDX_W-1:0] cfg_index = '0;
  logic [plbm_pkg::BP_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic m_tuser;

  piecewise_linear_breakpoint_map_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor's copy of the table
  logic [plbm_pkg::BP_W-1:0] bp_table [NPTS];
  logic [plbm_pkg::CNT_W-1:0] pts_reg;

  map_result_t pending_maps[$];
  int errors = 0;
  int beats_out = 0;
  int hold_off = 0;
  bit stall_enable = 1'b1;

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint seg_interp(longint x, longint x0, longint x1,
                                        longint y0, longint y1);
    longint den;
    den = x1 - x0;
    if (den == 0) return y0;
    return sat_word(y0 + ((x - x0) * (y1 - y0)) / den);
  endfunction

  function automatic map_result_t predict_map(plbm_pkg::kind_t kind,
                                              logic signed [31:0] operand);
    map_result_t r;
    int n;
    longint lo, hi, x, res, nrm [NPTS], rng [NPTS];
    n = pts_reg;
    if (n < 2) n = 2;
    if (n > NPTS) n = NPTS;
    for (int i = 0; i < NPTS; i++) begin
      nrm[i] = longint'({1'b0, bp_table[i][48:32]});
      rng[i] = longint'($signed(bp_table[i][31:0]));
    end
    lo = rng[0];
    hi = rng[n-1];
    x = longint'(operand);
    r.empty = 1'b0;
    if (hi - lo <= 0) begin
      r.value = '0;
      r.empty = 1'b1;
      return r;
    end
    if (kind == plbm_pkg::KIND_TO_RANGE) begin
      if (x < 0) x = 0;
      if (x > 65536) x = 65536;
      res = hi;
      for (int i = 0; i < n - 1; i++)
        if (x <= nrm[i+1]) begin
          res = seg_interp(x, nrm[i], nrm[i+1], rng[i], rng[i+1]);
          break;
        end
    end else begin
      if (x < lo) x = lo;
      if (x > hi) x = hi;
      res = 65536;
      for (int i = 0; i < n - 1; i++)
        if (x <= rng[i+1]) begin
          res = seg_interp(x, rng[i], rng[i+1], nrm[i], nrm[i+1]);
          break;
        end
    end
    r.value = res[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch beat %0d %s: got %0d want %0d", beats_out, what, got, want);
  endtask

  task automatic write_reg(logic [plbm_pkg::IDX_W-1:0] idx,
                           logic [plbm_pkg::BP_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx < NPTS) bp_table[idx] = data;
    else if (idx == plbm_pkg::REG_POINT_COUNT) pts_reg = data[plbm_pkg::CNT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [plbm_pkg::BP_W-1:0] pack_bp(int unsigned norm,
                                                      logic signed [31:0] rng);
    return {norm[16:0], rng};
  endfunction

  // waits for the pipeline to drain before touching registers
  task automatic drain;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // one beat, with random gaps between bursts
  int burst_left = 0;
  task automatic send_map(plbm_pkg::kind_t kind, logic signed [31:0] operand, logic known,
                          logic signed [31:0] value, logic empty);
    map_result_t r;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= operand;
    r = predict_map(kind, operand);
    if (known) begin
      if (r.value !== value) report_mismatch("directed row value", r.value, value);
      if (r.empty !== empty) report_mismatch("directed row flag", r.empty, empty);
      r.value = value;
      r.empty = empty;
    end
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_maps.push_back(r);
    @(negedge clk);
  endtask

  task automatic finish_send;
    s_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  // result checker
  always @(posedge clk) begin
    map_result_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_maps.size() == 0) begin
        report_mismatch("unexpected beat", $signed(m_tdata), 0);
      end else begin
        w = pending_maps.pop_front();
        if ($signed(m_tdata) !== w.value) report_mismatch("mapped_value", $signed(m_tdata), w.value);
        if (m_tuser !== w.empty) report_mismatch("empty_range", m_tuser, w.empty);
      end
      beats_out++;
    end
  end

  // receiver stall pattern, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_off > 0) begin
      m_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (!stall_enable) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  stim_row_t directed [$];
  int n_rand;
  int unsigned npt;

  task automatic add_row(plbm_pkg::kind_t k, logic signed [31:0] op, logic known,
                         logic signed [31:0] v, logic e);
    stim_row_t s;
    s.kind = k; s.operand = op; s.known = known; s.value = v; s.empty = e;
    directed.push_back(s);
  endtask

  task automatic random_table;
    int unsigned norms [NPTS];
    int signed rngs [NPTS];
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < NPTS; i++) begin
      norms[i] = $urandom_range(0, 131071);
      rngs[i] = $urandom;
    end
    if (mode < 7) begin
      // ordered table, sometimes with zero-width segments
      norms[0] = $urandom_range(0, 2000);
      rngs[0] = $urandom_range(0, 1) ? -$urandom_range(0, 32'h7fff0000) : $urandom_range(0, 1000);
      for (int i = 1; i < NPTS; i++) begin
        norms[i] = ($urandom_range(0, 5) == 0) ? norms[i-1]
                 : norms[i-1] + $urandom_range(0, 20000);
        if (norms[i] > 131071) norms[i] = 131071;
        rngs[i] = ($urandom_range(0, 5) == 0) ? rngs[i-1]
                : rngs[i-1] + $urandom_range(0, 32'h20000000);
      end
    end
    for (int i = 0; i < NPTS; i++)
      write_reg(plbm_pkg::IDX_W'(i), pack_bp(norms[i], rngs[i]));
    write_reg(plbm_pkg::REG_POINT_COUNT, plbm_pkg::BP_W'($urandom_range(0, 7)));
  endtask

  task automatic random_beat;
    logic signed [31:0] op;
    plbm_pkg::kind_t k;
    int sel;
    k = plbm_pkg::kind_t'($urandom_range(0, 1));
    sel = $urandom_range(0, 9);
    if (sel < 2) op = $urandom;
    else if (k == plbm_pkg::KIND_TO_RANGE) op = $urandom_range(0, 70000) - 2000;
    else op = $signed(bp_table[$urandom_range(0, NPTS-1)][31:0]) + $urandom_range(0, 2000000) - 1000000;
    send_map(k, op, 1'b0, '0, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < NPTS; i++) bp_table[i] = '0;
    pts_reg = plbm_pkg::POINT_COUNT_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // after reset the range is empty
    add_row(plbm_pkg::KIND_TO_RANGE, 32'sd0, 1'b1, 32'sd0, 1'b1);
    add_row(plbm_pkg::KIND_TO_NORM, 32'sh7fffffff, 1'b1, 32'sd0, 1'b1);
    foreach (directed[i])
      send_map(directed[i].kind, directed[i].operand, directed[i].known,
               directed[i].value, directed[i].empty);
    finish_send();
    drain();

    // extremes of the range: 0..1 maps to min..max
    write_reg(3'd0, pack_bp(0, 32'sh80000000));
    write_reg(3'd1, pack_bp(65536, 32'sh7fffffff));
    write_reg(3'd2, pack_bp(65536, 32'sh7fffffff));
    write_reg(3'd3, pack_bp(0, 32'sd0));
    write_reg(3'd4, pack_bp(131071, 32'sd0));
    write_reg(3'd5, pack_bp(0, 32'sh80000000));
    write_reg(plbm_pkg::REG_POINT_COUNT, plbm_pkg::BP_W'(2));
    directed.delete();
    add_row(plbm_pkg::KIND_TO_RANGE, 32'sh80000000, 1'b1, 32'sh80000000, 1'b0);
    add_row(plbm_pkg::KIND_TO_RANGE, 32'sh7fffffff, 1'b1, 32'sh7fffffff, 1'b0);
    add_row(plbm_pkg::KIND_TO_RANGE, 32'sd0, 1'b1, 32'sh80000000, 1'b0);
    add_row(plbm_pkg::KIND_TO_RANGE, 32'sd65536, 1'b1, 32'sh7fffffff, 1'b0);
    add_row(plbm_pkg::KIND_TO_RANGE, 32'sd32768, 1'b0, '0, 1'b0);
    add_row(plbm_pkg::KIND_TO_NORM, 32'sh80000000, 1'b1, 32'sd0, 1'b0);
    add_row(plbm_pkg::KIND_TO_NORM, 32'sh7fffffff, 1'b1, 32'sd65536, 1'b0);
    add_row(plbm_pkg::KIND_TO_NORM, 32'sd0, 1'b0, '0, 1'b0);
    add_row(plbm_pkg::KIND_TO_NORM, 32'sd12345, 1'b0, '0, 1'b0);
    foreach (directed[i])
      send_map(directed[i].kind, directed[i].operand, directed[i].known,
               directed[i].value, directed[i].empty);
    finish_send();
    drain();

    // six points: zero-width segment, no match, unordered tail saturating
    write_reg(3'd0, pack_bp(1000, -32'sd100));
    write_reg(3'd1, pack_bp(1000, 32'sd500));
    write_reg(3'd2, pack_bp(30000, 32'sd500));
    write_reg(3'd3, pack_bp(40000, 32'sd90000));
    write_reg(3'd4, pack_bp(20000, 32'sh7fff0000));
    write_reg(3'd5, pack_bp(131071, 32'sd100000));
    write_reg(plbm_pkg::REG_POINT_COUNT, plbm_pkg::BP_W'(7));
    directed.delete();
    add_row(plbm_pkg::KIND_TO_RANGE, 32'sd0, 1'b1, -32'sd100, 1'b0);
    add_row(plbm_pkg::KIND_TO_RANGE, 32'sd1000, 1'b1, -32'sd100, 1'b0);
    add_row(plbm_pkg::KIND_TO_RANGE, 32'sd35000, 1'b0, '0, 1'b0);
    add_row(plbm_pkg::KIND_TO_RANGE, 32'sd65536, 1'b0, '0, 1'b0);
    add_row(plbm_pkg::KIND_TO_RANGE, -32'sd5, 1'b0, '0, 1'b0);
    add_row(plbm_pkg::KIND_TO_NORM, 32'sd500, 1'b0, '0, 1'b0);
    add_row(plbm_pkg::KIND_TO_NORM, 32'sd95000, 1'b0, '0, 1'b0);
    add_row(plbm_pkg::KIND_TO_NORM, 32'sd200000, 1'b0, '0, 1'b0);
    add_row(plbm_pkg::KIND_TO_NORM, 32'sh80000000, 1'b0, '0, 1'b0);
    foreach (directed[i])
      send_map(directed[i].kind, directed[i].operand, directed[i].known,
               directed[i].value, directed[i].empty);
    finish_send();
    drain();

    // random phases; one phase holds the output off for a long stretch
    n_rand = 0;
    for (int ph = 0; ph < 8; ph++) begin
      random_table();
      stall_enable = (ph % 3 != 2);
      if (ph == 3) begin
        @(negedge clk);
        hold_off = 200;
      end
      for (int j = 0; j < 50; j++) begin
        random_beat();
        n_rand++;
      end
      finish_send();
      drain();
    end

    if (pending_maps.size() != 0) begin
      errors++;
      $display("%0d results never arrived", pending_maps.size());
    end
    $display("covered reset, extremes, zero-width and unmatched segments, saturation,");
    $display("%0d random beats over 8 tables, %0d results checked", n_rand, beats_out);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/plbm_pkg.sv
hw/rtl/plbm_div.sv
hw/rtl/piecewise_linear_breakpoint_map_unit.sv
dv/tb_top.sv
